### design/mlq_slot_credit_scheduler_assert.svh
// Assertion macros used by the scheduler's top-level RTL file.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef MLQ_SLOT_CREDIT_SCHEDULER_ASSERT_SVH
`define MLQ_SLOT_CREDIT_SCHEDULER_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define MSCS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MSCS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mscs_pkg.sv
// Shared types and fixed widths of the multilevel slot-credit scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mscs_pkg;

  // Fixed widths of the beat fields and of the credit counters.
  localparam int unsigned PID_W    = 8;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned CREDIT_W = 8;

  // Command field codes.
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } command_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_GRANTED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // carry out the captured command
  } ctrl_t;

endpackage

`default_nettype wire

### design/mlq_slot_credit_scheduler.sv
// Multilevel ready-queue scheduler with slot credits: a result beat strobes on done_o in the respond
// state that follows the execute state; no beat is taken while one executes, but one is taken while responding.
// The id store is a single-port memory read and written in the execute cycle.
// Reset leaves every queue empty and every credit at its reload value; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module mlq_slot_credit_scheduler #(
  parameter int unsigned NUM_PRIO    = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          command_i,
  input  wire logic [mscs_pkg::PID_W-1:0]    proc_id_i,
  input  wire logic [mscs_pkg::LEVEL_W-1:0]  level_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [mscs_pkg::PID_W-1:0]         granted_id_o,
  output logic [mscs_pkg::LEVEL_W-1:0]       granted_level_o
);

`include "mlq_slot_credit_scheduler_assert.svh"

  mscs_pkg::ctrl_t ctrl;

  // Sequencing.
  mscs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // Queues, credits and pick.
  mscs_datapath #(
    .NUM_PRIO    (NUM_PRIO),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .command_i       (command_i),
    .proc_id_i       (proc_id_i),
    .level_i         (level_i),
    .status_o        (status_o),
    .granted_id_o    (granted_id_o),
    .granted_level_o (granted_level_o)
  );

  // Each accepted beat is executed in the next cycle and answered in the one after.
  `MSCS_ASSERT(a_accept_exec, clk_i, rst_ni, (start && !busy) |=> busy, "accepted beat not executed")
  `MSCS_ASSERT(a_exec_done, clk_i, rst_ni, busy |=> (done_o && !busy) || (done_o && busy), "execute not followed by a result")
  `MSCS_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(busy), "result without an execute cycle")
  `MSCS_ASSERT(a_no_grant_zero, clk_i, rst_ni, (done_o && (status_o != mscs_pkg::ST_GRANTED)) |-> ((granted_id_o == '0) && (granted_level_o == '0)), "grant fields not zero")
  `MSCS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!done_o && !busy), "activity during reset")

endmodule

`default_nettype wire

### design/mscs_ctrl.sv
// Controller state machine of the scheduler: sequences capture, execute and respond.
// Depends on mscs_pkg.
`default_nettype none

module mscs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output mscs_pkg::ctrl_t    ctrl_o
);

  mscs_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mscs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a beat is taken whenever the datapath is not executing.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mscs_pkg::S_IDLE,
      mscs_pkg::S_RESP: begin
        state_d = start ? mscs_pkg::S_EXEC : mscs_pkg::S_IDLE;
      end
      mscs_pkg::S_EXEC: begin
        state_d = mscs_pkg::S_RESP;
      end
      default: begin
        state_d = mscs_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    busy        = 1'b0;
    done_o      = 1'b0;
    ctrl_o.load = 1'b0;
    ctrl_o.exec = 1'b0;
    unique case (state_q)
      mscs_pkg::S_IDLE: begin
        ctrl_o.load = start;
      end
      mscs_pkg::S_EXEC: begin
        busy        = 1'b1;
        ctrl_o.exec = 1'b1;
      end
      mscs_pkg::S_RESP: begin
        done_o      = 1'b1;
        ctrl_o.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mscs_datapath.sv
// Datapath of the scheduler: per-level FIFO pointers, credits, pick logic and id store.
// Depends on mscs_pkg; driven by mscs_ctrl through an mscs_pkg::ctrl_t bundle.
`default_nettype none

module mscs_datapath #(
  parameter int unsigned NUM_PRIO    = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mscs_pkg::ctrl_t               ctrl_i,
  input  wire logic                          command_i,
  input  wire logic [mscs_pkg::PID_W-1:0]    proc_id_i,
  input  wire logic [mscs_pkg::LEVEL_W-1:0]  level_i,
  output logic [1:0]                         status_o,
  output logic [mscs_pkg::PID_W-1:0]         granted_id_o,
  output logic [mscs_pkg::LEVEL_W-1:0]       granted_level_o
);

  // Only levels that the level field can name ever hold work.
  localparam int unsigned MaxLvl = 1 << mscs_pkg::LEVEL_W;
  localparam int unsigned NLVL   = (NUM_PRIO < MaxLvl) ? NUM_PRIO : MaxLvl;
  localparam int unsigned LW     = $clog2(NLVL);
  localparam int unsigned IW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned AW     = LW + IW;
  localparam int unsigned CRW    = mscs_pkg::CREDIT_W;

  // Credit that a level reloads to.
  function automatic logic [CRW-1:0] reload_val(input int unsigned lvl);
    return CRW'(NUM_PRIO - lvl);
  endfunction

  // Captured beat.
  logic                          cmd_q;
  logic [mscs_pkg::PID_W-1:0]    pid_q;
  logic [mscs_pkg::LEVEL_W-1:0]  level_q;

  // Per-level state.
  logic [IW-1:0]  head_q   [NLVL];
  logic [IW-1:0]  head_d   [NLVL];
  logic [CW-1:0]  count_q  [NLVL];
  logic [CW-1:0]  count_d  [NLVL];
  logic [CRW-1:0] credit_q [NLVL];
  logic [CRW-1:0] credit_d [NLVL];

  // Result registers.
  mscs_pkg::status_e            status_q, status_d;
  logic                         grant_q, grant_d;
  logic [mscs_pkg::LEVEL_W-1:0] glvl_q, glvl_d;
  logic [mscs_pkg::PID_W-1:0]   rd_q;

  // Id store, one row of QUEUE_DEPTH entries per level.
  logic [mscs_pkg::PID_W-1:0] store_q [2**AW];

  // Pick and pointer arithmetic.
  logic [NLVL-1:0] nonempty, elig, pick_vec;
  logic            any_work, any_elig, reload;
  logic [LW-1:0]   sel, lvl_idx, hidx;
  logic [IW-1:0]   head_sel, tail, head_next;
  logic [CW-1:0]   count_lvl;
  logic [SW-1:0]   tail_sum;
  logic            lvl_ok, add_ok, do_grant, wr_en;

  // Capture the beat on acceptance.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= command_i;
      pid_q   <= proc_id_i;
      level_q <= level_i;
    end
  end

  // Eligibility and priority pick; a grant made with no eligible level reloads every credit.
  always_comb begin
    for (int unsigned i = 0; i < NLVL; i++) begin
      nonempty[i] = (count_q[i] != '0);
      elig[i]     = nonempty[i] && (credit_q[i] != '0);
    end
    any_work = |nonempty;
    any_elig = |elig;
    reload   = !any_elig;
    pick_vec = any_elig ? elig : nonempty;
    sel      = '0;
    for (int i = int'(NLVL) - 1; i >= 0; i--) begin
      if (pick_vec[i]) begin
        sel = LW'(i);
      end
    end
  end

  // Head and tail of the addressed level.
  always_comb begin
    lvl_idx   = level_q[LW-1:0];
    lvl_ok    = (32'(level_q) < NLVL);
    hidx      = (cmd_q == mscs_pkg::CMD_GET) ? sel : lvl_idx;
    head_sel  = head_q[hidx];
    count_lvl = count_q[lvl_idx];
    tail_sum  = SW'(head_sel) + SW'(count_lvl);
    tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                : IW'(tail_sum);
    head_next = (head_sel == IW'(QUEUE_DEPTH - 1)) ? '0 : IW'(head_sel + 1'b1);
    add_ok    = lvl_ok && (count_lvl != CW'(QUEUE_DEPTH));
    do_grant  = ctrl_i.exec && (cmd_q == mscs_pkg::CMD_GET) && any_work;
    wr_en     = ctrl_i.exec && (cmd_q == mscs_pkg::CMD_ADD) && add_ok;
  end

  // State update and result for the executed command.
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    credit_d = credit_q;
    status_d = status_q;
    grant_d  = grant_q;
    glvl_d   = glvl_q;
    if (ctrl_i.exec) begin
      grant_d = do_grant;
      glvl_d  = do_grant ? mscs_pkg::LEVEL_W'(sel) : '0;
      if (cmd_q == mscs_pkg::CMD_ADD) begin
        status_d = add_ok ? mscs_pkg::ST_ADDED : mscs_pkg::ST_DROPPED;
      end else begin
        status_d = any_work ? mscs_pkg::ST_GRANTED : mscs_pkg::ST_EMPTY;
      end
    end
    for (int unsigned i = 0; i < NLVL; i++) begin
      if (wr_en && (lvl_idx == LW'(i))) begin
        count_d[i] = CW'(count_q[i] + 1'b1);
      end
      if (do_grant) begin
        if (reload) begin
          credit_d[i] = reload_val(i);
        end
        if (sel == LW'(i)) begin
          head_d[i]   = head_next;
          count_d[i]  = CW'(count_q[i] - 1'b1);
          credit_d[i] = reload ? CRW'(reload_val(i) - 1'b1) : CRW'(credit_q[i] - 1'b1);
        end
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NLVL; i++) begin
        head_q[i]   <= '0;
        count_q[i]  <= '0;
        credit_q[i] <= reload_val(i);
      end
      status_q <= mscs_pkg::ST_ADDED;
      grant_q  <= 1'b0;
      glvl_q   <= '0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      credit_q <= credit_d;
      status_q <= status_d;
      grant_q  <= grant_d;
      glvl_q   <= glvl_d;
    end
  end

  // Store write on an accepted add, registered read of the granted head.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[{lvl_idx, tail}] <= pid_q;
    end
    if (do_grant) begin
      rd_q <= store_q[{sel, head_sel}];
    end
  end

  // Result beat.
  assign status_o        = status_q;
  assign granted_id_o    = grant_q ? rd_q : '0;
  assign granted_level_o = glvl_q;

endmodule

`default_nettype wire
